// ===== hw/rtl/gdfw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_pkg
// Shared types and codes of the depth-first graph walker: command and
// result codes, controller states and the control/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package gdfw_pkg;

    localparam int VERTICES_DEF   = 64;
    localparam int EDGE_SLOTS_DEF = 512;
    localparam int VERTEX_W       = 6;
    localparam int CMD_W          = 2;
    localparam int KIND_W         = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WALK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_VISIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEARED = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_RD_A,
        ST_ADD_WR_A,
        ST_ADD_RD_B,
        ST_ADD_WR_B,
        ST_EMIT,
        ST_W_START,
        ST_W_HEAD,
        ST_W_STEP,
        ST_W_SLOT,
        ST_W_PUSH,
        ST_W_POP,
        ST_W_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load_in;     // latch the accepted request
        logic              rd_head_a;   // read list head of endpoint a
        logic              rd_head_b;   // read list head of endpoint b
        logic              link_a;      // link b into the list of a
        logic              link_b;      // link a into the list of b
        logic              clear;       // empty lists, free slots, clear marks
        logic              w_start;     // mark start vertex, read its head
        logic              w_head;      // open the bottom stack frame
        logic              rd_slot;     // read the slot under the top cursor
        logic              slot_skip;   // neighbor already marked: advance cursor
        logic              w_visit;     // mark neighbor, save frame, read its head
        logic              w_push;      // open a new top frame
        logic              rd_stack;    // read the frame below the top
        logic              w_pop;       // drop the top frame
        logic              out_load;    // load the result register
        logic [KIND_W-1:0] out_kind;
        logic              out_last;
        logic              out_pending; // result carries the pending vertex
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             a_ok;       // vertex_a is a vertex of the graph
        logic             b_ok;       // vertex_b is a vertex of the graph
        logic             full;       // fewer than two free slots
        logic             top_nil;    // top frame has no entries left
        logic             depth_one;  // only the bottom frame is open
        logic             w_seen;     // neighbor just read is already marked
        logic             out_free;   // result register can take a new result
    } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gdfw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_ctrl
// Sequencer of the walker: decodes each request and steps the datapath
// through edge insertion, clear, or the stack-driven depth-first walk.
// ----------------------------------------------------------------------------
module gdfw_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire gdfw_pkg::sts_t sts,
    output gdfw_pkg::ctl_t     ctl
);

    gdfw_pkg::state_t                     state_reg, state_next;
    logic [gdfw_pkg::KIND_W-1:0]          emit_kind_reg, emit_kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gdfw_pkg::ST_IDLE;
            emit_kind_reg <= gdfw_pkg::KIND_VISIT;
        end else begin
            state_reg     <= state_next;
            emit_kind_reg <= emit_kind_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        emit_kind_next = emit_kind_reg;
        ctl            = '0;
        s_tready       = 1'b0;
        unique case (state_reg)
            gdfw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.load_in = 1'b1;
                    state_next  = gdfw_pkg::ST_DECODE;
                end
            end
            gdfw_pkg::ST_DECODE: begin
                unique case (sts.cmd)
                    gdfw_pkg::CMD_ADD: begin
                        if (!sts.a_ok || !sts.b_ok || sts.full) begin
                            emit_kind_next = gdfw_pkg::KIND_FULL;
                            state_next     = gdfw_pkg::ST_EMIT;
                        end else begin
                            state_next = gdfw_pkg::ST_ADD_RD_A;
                        end
                    end
                    gdfw_pkg::CMD_WALK: begin
                        state_next = sts.a_ok ? gdfw_pkg::ST_W_START : gdfw_pkg::ST_IDLE;
                    end
                    gdfw_pkg::CMD_CLEAR: begin
                        ctl.clear      = 1'b1;
                        emit_kind_next = gdfw_pkg::KIND_CLEARED;
                        state_next     = gdfw_pkg::ST_EMIT;
                    end
                    default: begin
                        state_next = gdfw_pkg::ST_IDLE;
                    end
                endcase
            end
            gdfw_pkg::ST_ADD_RD_A: begin
                ctl.rd_head_a = 1'b1;
                state_next    = gdfw_pkg::ST_ADD_WR_A;
            end
            gdfw_pkg::ST_ADD_WR_A: begin
                ctl.link_a = 1'b1;
                state_next = gdfw_pkg::ST_ADD_RD_B;
            end
            gdfw_pkg::ST_ADD_RD_B: begin
                // Read after the first link so that a self loop sees it.
                ctl.rd_head_b = 1'b1;
                state_next    = gdfw_pkg::ST_ADD_WR_B;
            end
            gdfw_pkg::ST_ADD_WR_B: begin
                ctl.link_b     = 1'b1;
                emit_kind_next = gdfw_pkg::KIND_ADDED;
                state_next     = gdfw_pkg::ST_EMIT;
            end
            gdfw_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    ctl.out_kind = emit_kind_reg;
                    ctl.out_last = 1'b1;
                    state_next   = gdfw_pkg::ST_IDLE;
                end
            end
            gdfw_pkg::ST_W_START: begin
                ctl.w_start = 1'b1;
                state_next  = gdfw_pkg::ST_W_HEAD;
            end
            gdfw_pkg::ST_W_HEAD: begin
                ctl.w_head = 1'b1;
                state_next = gdfw_pkg::ST_W_STEP;
            end
            gdfw_pkg::ST_W_STEP: begin
                if (!sts.top_nil) begin
                    ctl.rd_slot = 1'b1;
                    state_next  = gdfw_pkg::ST_W_SLOT;
                end else if (sts.depth_one) begin
                    state_next = gdfw_pkg::ST_W_DONE;
                end else begin
                    ctl.rd_stack = 1'b1;
                    state_next   = gdfw_pkg::ST_W_POP;
                end
            end
            gdfw_pkg::ST_W_SLOT: begin
                if (sts.w_seen) begin
                    ctl.slot_skip = 1'b1;
                    state_next    = gdfw_pkg::ST_W_STEP;
                end else if (sts.out_free) begin
                    // The previously reached vertex is known not to be the
                    // last one, so it goes out now.
                    ctl.w_visit     = 1'b1;
                    ctl.out_load    = 1'b1;
                    ctl.out_kind    = gdfw_pkg::KIND_VISIT;
                    ctl.out_pending = 1'b1;
                    state_next      = gdfw_pkg::ST_W_PUSH;
                end
            end
            gdfw_pkg::ST_W_PUSH: begin
                ctl.w_push = 1'b1;
                state_next = gdfw_pkg::ST_W_STEP;
            end
            gdfw_pkg::ST_W_POP: begin
                ctl.w_pop  = 1'b1;
                state_next = gdfw_pkg::ST_W_STEP;
            end
            gdfw_pkg::ST_W_DONE: begin
                if (sts.out_free) begin
                    ctl.out_load    = 1'b1;
                    ctl.out_kind    = gdfw_pkg::KIND_VISIT;
                    ctl.out_pending = 1'b1;
                    ctl.out_last    = 1'b1;
                    state_next      = gdfw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gdfw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/gdfw_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_dp
// Datapath of the walker: list heads, the shared slot store, the frame
// stack, visited marks, counters and the result register.
// ----------------------------------------------------------------------------
module gdfw_dp #(
    parameter int VERTICES   = gdfw_pkg::VERTICES_DEF,
    parameter int EDGE_SLOTS = gdfw_pkg::EDGE_SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [gdfw_pkg::CMD_W-1:0]      in_cmd,
    input  wire logic [gdfw_pkg::VERTEX_W-1:0]   in_vertex_a,
    input  wire logic [gdfw_pkg::VERTEX_W-1:0]   in_vertex_b,
    input  wire gdfw_pkg::ctl_t                  ctl,
    output gdfw_pkg::sts_t                       sts,
    input  wire logic                            m_tready,
    output logic                                 out_valid,
    output logic [gdfw_pkg::KIND_W-1:0]          out_kind,
    output logic [gdfw_pkg::VERTEX_W-1:0]        out_vertex,
    output logic                                 out_last
);

    localparam int VW  = $clog2(VERTICES);
    localparam int SW  = $clog2(EDGE_SLOTS);
    localparam int UW  = $clog2(EDGE_SLOTS + 1);
    localparam int DW  = $clog2(VERTICES + 1);
    localparam int PW  = SW + 1;              // cursor: empty flag and slot index
    localparam int EW  = VW + PW;             // slot entry: neighbor and next cursor
    localparam int CW  = gdfw_pkg::VERTEX_W + 1;

    // Latched request.
    logic [gdfw_pkg::CMD_W-1:0]    cmd_reg;
    logic [gdfw_pkg::VERTEX_W-1:0] a_reg, b_reg;

    // Storage.
    logic [SW-1:0]       head_mem  [VERTICES];
    logic [EW-1:0]       slot_mem  [EDGE_SLOTS];
    logic [PW-1:0]       stack_mem [VERTICES];
    logic [VERTICES-1:0] head_valid_reg;
    logic [VERTICES-1:0] visited_reg;

    logic [SW-1:0] head_rd_reg;
    logic          head_nil_reg;
    logic [EW-1:0] slot_rd_reg;
    logic [PW-1:0] stack_rd_reg;

    logic [UW-1:0] used_reg;
    logic [DW-1:0] depth_reg;
    logic [PW-1:0] top_reg;
    logic [VW-1:0] pend_reg;

    logic [gdfw_pkg::KIND_W-1:0]   out_kind_reg;
    logic [gdfw_pkg::VERTEX_W-1:0] out_vertex_reg;
    logic                          out_last_reg;
    logic                          out_valid_reg;

    logic [VW-1:0] a_idx, b_idx, nbr, head_addr;
    logic [PW-1:0] slot_next;
    logic [DW-1:0] depth_m1, depth_m2;
    logic          head_re;

    assign a_idx     = a_reg[VW-1:0];
    assign b_idx     = b_reg[VW-1:0];
    assign nbr       = slot_rd_reg[EW-1:PW];
    assign slot_next = slot_rd_reg[PW-1:0];
    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);

    assign head_re = ctl.rd_head_a | ctl.rd_head_b | ctl.w_start | ctl.w_visit;

    always_comb begin
        head_addr = a_idx;
        if (ctl.rd_head_b) begin
            head_addr = b_idx;
        end else if (ctl.w_visit) begin
            head_addr = nbr;
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.a_ok      = CW'(a_reg) < CW'(VERTICES);
    assign sts.b_ok      = CW'(b_reg) < CW'(VERTICES);
    assign sts.full      = used_reg > UW'(EDGE_SLOTS - 2);
    assign sts.top_nil   = top_reg[SW];
    assign sts.depth_one = depth_reg == DW'(1);
    assign sts.w_seen    = visited_reg[nbr];
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Request and payload registers.
    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg <= in_cmd;
            a_reg   <= in_vertex_a;
            b_reg   <= in_vertex_b;
        end
        if (ctl.w_start) begin
            pend_reg <= a_idx;
        end else if (ctl.w_visit) begin
            pend_reg <= nbr;
        end
        if (ctl.w_head || ctl.w_push) begin
            top_reg <= {head_nil_reg, head_rd_reg};
        end else if (ctl.slot_skip) begin
            top_reg <= slot_next;
        end else if (ctl.w_pop) begin
            top_reg <= stack_rd_reg;
        end
        if (ctl.out_load) begin
            out_kind_reg   <= ctl.out_kind;
            out_vertex_reg <= ctl.out_pending ? gdfw_pkg::VERTEX_W'(pend_reg) : '0;
            out_last_reg   <= ctl.out_last;
        end
    end

    // List heads: the array holds slot indexes, the valid bits say which
    // lists are non-empty.
    always_ff @(posedge aclk) begin
        if (head_re) begin
            head_rd_reg  <= head_mem[head_addr];
            head_nil_reg <= !head_valid_reg[head_addr];
        end
        if (ctl.link_a) begin
            head_mem[a_idx] <= used_reg[SW-1:0];
        end else if (ctl.link_b) begin
            head_mem[b_idx] <= used_reg[SW-1:0];
        end
    end

    // Slot store: a new entry points at the old head of its owner's list.
    always_ff @(posedge aclk) begin
        if (ctl.rd_slot) begin
            slot_rd_reg <= slot_mem[top_reg[SW-1:0]];
        end
        if (ctl.link_a) begin
            slot_mem[used_reg[SW-1:0]] <= {b_idx, head_nil_reg, head_rd_reg};
        end else if (ctl.link_b) begin
            slot_mem[used_reg[SW-1:0]] <= {a_idx, head_nil_reg, head_rd_reg};
        end
    end

    // Frame stack: the top frame's cursor lives in top_reg, the frames
    // below it are at indexes zero to depth minus two.
    always_ff @(posedge aclk) begin
        if (ctl.rd_stack) begin
            stack_rd_reg <= stack_mem[depth_m2[VW-1:0]];
        end
        if (ctl.w_visit) begin
            stack_mem[depth_m1[VW-1:0]] <= slot_next;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
            visited_reg    <= '0;
            used_reg       <= '0;
            depth_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (ctl.clear) begin
                head_valid_reg <= '0;
                visited_reg    <= '0;
                used_reg       <= '0;
            end else begin
                if (ctl.link_a) begin
                    head_valid_reg[a_idx] <= 1'b1;
                end else if (ctl.link_b) begin
                    head_valid_reg[b_idx] <= 1'b1;
                end
                if (ctl.link_a || ctl.link_b) begin
                    used_reg <= used_reg + UW'(1);
                end
                if (ctl.w_start) begin
                    visited_reg[a_idx] <= 1'b1;
                end else if (ctl.w_visit) begin
                    visited_reg[nbr] <= 1'b1;
                end
            end
            if (ctl.w_head) begin
                depth_reg <= DW'(1);
            end else if (ctl.w_push) begin
                depth_reg <= depth_reg + DW'(1);
            end else if (ctl.w_pop) begin
                depth_reg <= depth_m1;
            end
            if (ctl.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_vertex = out_vertex_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/graph_depth_first_walker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// graph_depth_first_walker
// Undirected graph held as adjacency lists in a shared slot store, with
// edge insertion, clear, and a depth-first walk driven by a frame stack.
//
//   channel | dir | tdata                        | tuser       | tlast
//   s_      | in  | [5:0] vertex_a [11:6] vertex_b | [1:0] command | -
//   m_      | out | [5:0] vertex                 | [1:0] kind  | last
//
// One request at a time. An add edge reads and links the list of vertex_a,
// then that of vertex_b; a rejected add or a clear goes straight to its
// result. A walk reads one slot at a time through the single read port of
// the slot store, and drops a frame through the single read port of the
// stack. Reset clears the list-valid bits and visited marks at once: no
// clearing pass. A stalled result register holds the walk at the next vertex
// found, and the next request is taken while the final result still waits.
// ----------------------------------------------------------------------------
module graph_depth_first_walker #(
    parameter int VERTICES   = gdfw_pkg::VERTICES_DEF,
    parameter int EDGE_SLOTS = gdfw_pkg::EDGE_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [5:0] vertex_a, [11:6] vertex_b
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [5:0] vertex
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast
);

    gdfw_pkg::ctl_t ctl;
    gdfw_pkg::sts_t sts;

    logic [gdfw_pkg::VERTEX_W-1:0] out_vertex;

    gdfw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    gdfw_dp #(
        .VERTICES   (VERTICES),
        .EDGE_SLOTS (EDGE_SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_cmd      (s_tuser),
        .in_vertex_a (s_tdata[5:0]),
        .in_vertex_b (s_tdata[11:6]),
        .ctl         (ctl),
        .sts         (sts),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_kind    (m_tuser),
        .out_vertex  (out_vertex),
        .out_last    (m_tlast)
    );

    assign m_tdata = {2'b00, out_vertex};

    // Every accepted request takes the block out of its ready state in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // A result is only loaded when the result register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |-> sts.out_free)
        else $error("result register overwritten");

    // The bottom frame is never popped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.rd_stack |-> !sts.depth_one)
        else $error("frame stack underflow");

    // A marked vertex is never reported again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.w_visit |-> !sts.w_seen)
        else $error("marked vertex visited twice");

endmodule
`default_nettype wire

// ===== tb/sv/graph_depth_first_walker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_depth_first_walker_test
// Self-checking bench for the depth-first graph walker. Edge, walk and clear
// requests go in on the s_ stream, and a scoreboard keeps its own copy of
// the adjacency lists and visited marks. It predicts every visit, edge and
// clear report and compares each one that comes out on the m_ stream, field
// by field and in order. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module graph_depth_first_walker_test;

    localparam int NUM_VERTICES = 64;
    localparam int NUM_SLOTS    = 512;
    localparam int RANDOM_ITEMS = 220;
    localparam int FILL_AFTER   = 30;
    localparam int IDLE_LIMIT   = 20000;
    localparam logic [gdfw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [gdfw_pkg::KIND_W-1:0]   kind;
        logic [gdfw_pkg::VERTEX_W-1:0] vertex;
        logic                          last;
    } graph_report_t;

    // Keeps a private copy of the graph and predicts the reports of each request.
    class walker_scoreboard;
        int            list_head[NUM_VERTICES];   // -1 marks an empty list
        int            slot_nbr[NUM_SLOTS];
        int            slot_next[NUM_SLOTS];
        int            slots_used;
        bit            marked[NUM_VERTICES];
        graph_report_t burst[$];
        graph_report_t awaited[$];
        int            errors;
        int            edges_added, store_full, walks, clears, reports_checked;
        int            longest_walk;

        function new();
            wipe_graph();
        endfunction

        function void wipe_graph();
            for (int i = 0; i < NUM_VERTICES; i++) begin
                list_head[i] = -1;
                marked[i] = 1'b0;
            end
            slots_used = 0;
        endfunction

        function void add_report(logic [gdfw_pkg::KIND_W-1:0] kind, int vertex);
            graph_report_t r;
            r.kind = kind;
            r.vertex = vertex[gdfw_pkg::VERTEX_W-1:0];
            r.last = 1'b0;
            burst.push_back(r);
        endfunction

        function void link_entry(int owner, int nbr);
            slot_nbr[slots_used] = nbr;
            slot_next[slots_used] = list_head[owner];
            list_head[owner] = slots_used;
            slots_used++;
        endfunction

        function void walk_from(int src);
            int cursor[NUM_VERTICES];
            int depth;
            int p;
            int w;
            marked[src] = 1'b1;
            add_report(gdfw_pkg::KIND_VISIT, src);
            cursor[0] = list_head[src];
            depth = 1;
            while (depth > 0) begin
                p = cursor[depth-1];
                if (p < 0) begin
                    depth--;
                end else begin
                    w = slot_nbr[p];
                    cursor[depth-1] = slot_next[p];
                    if (!marked[w]) begin
                        marked[w] = 1'b1;
                        add_report(gdfw_pkg::KIND_VISIT, w);
                        cursor[depth] = list_head[w];
                        depth++;
                    end
                end
            end
            if (burst.size() > longest_walk)
                longest_walk = burst.size();
        endfunction

        function void take_request(logic [gdfw_pkg::CMD_W-1:0] cmd, logic [5:0] a,
                                   logic [5:0] b);
            burst.delete();
            case (cmd)
                gdfw_pkg::CMD_ADD: begin
                    if (slots_used + 2 > NUM_SLOTS) begin
                        add_report(gdfw_pkg::KIND_FULL, 0);
                        store_full++;
                    end else begin
                        link_entry(a, b);
                        link_entry(b, a);
                        add_report(gdfw_pkg::KIND_ADDED, 0);
                        edges_added++;
                    end
                end
                gdfw_pkg::CMD_WALK: begin
                    walk_from(a);
                    walks++;
                end
                gdfw_pkg::CMD_CLEAR: begin
                    wipe_graph();
                    add_report(gdfw_pkg::KIND_CLEARED, 0);
                    clears++;
                end
                default: ;
            endcase
            if (burst.size() > 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                awaited.push_back(burst[i]);
        endfunction

        function void check_report(logic [1:0] kind, logic [5:0] vertex, logic last);
            graph_report_t exp_r;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected report kind=%0d vertex=%0d last=%0b",
                         $time, kind, vertex, last);
                errors++;
                return;
            end
            exp_r = awaited.pop_front();
            reports_checked++;
            if (kind !== exp_r.kind) begin
                $display("%0t: kind mismatch, expected %0d, actual %0d",
                         $time, exp_r.kind, kind);
                errors++;
            end
            if (vertex !== exp_r.vertex) begin
                $display("%0t: vertex mismatch, expected %0d, actual %0d",
                         $time, exp_r.vertex, vertex);
                errors++;
            end
            if (last !== exp_r.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, exp_r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [5:0] vertex_a, [11:6] vertex_b
    logic [1:0]  s_tuser;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [5:0] vertex
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        m_tlast;

    walker_scoreboard book = new();
    bit steady;             // no idling on either side while set
    int stall_left;
    int idle_cycles;
    int requests_sent;

    graph_depth_first_walker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: take reports and stall at random.
    initial begin
        m_tready = 1'b0;
        stall_left = 0;
    end

    always @(posedge aclk) begin : receive_reports
        int g;
        if (m_tvalid && m_tready)
            book.check_report(m_tuser, m_tdata[5:0], m_tlast);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = g - 1;
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or report moved for %0d cycles", $time, IDLE_LIMIT);
            $display("graph_depth_first_walker_test NOT OK");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(logic [1:0] cmd, logic [5:0] a, logic [5:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0000, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.take_request(cmd, a, b);
        requests_sent++;
    endtask

    // Holds the sender off until every predicted report has come out.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (book.awaited.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic fill_store();
        send_request(gdfw_pkg::CMD_CLEAR, 6'd0, 6'd0);
        // A chain through every vertex, so the walk below reaches all of them.
        for (int i = 0; i < NUM_VERTICES - 1; i++)
            send_request(gdfw_pkg::CMD_ADD, 6'(i), 6'(i + 1));
        while (book.slots_used + 2 <= NUM_SLOTS)
            send_request(gdfw_pkg::CMD_ADD, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
        repeat (3)
            send_request(gdfw_pkg::CMD_ADD, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)));
        send_request(gdfw_pkg::CMD_WALK, 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)));
        send_request(gdfw_pkg::CMD_WALK, 6'($urandom_range(0, 63)), 6'd0);
        send_request(gdfw_pkg::CMD_CLEAR, 6'd0, 6'd0);
    endtask

    initial begin : stimulus
        int counted;
        int r;
        int lo;
        int n;
        int before_fill;
        bit store_filled;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        steady = 1'b1;
        requests_sent = 0;
        idle_cycles = 0;
        store_filled = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests: range extremes, repeated edge, self loop,
        // walks from marked and isolated vertices, unused command, clear.
        send_request(gdfw_pkg::CMD_WALK, 6'd7, 6'd0);
        send_request(gdfw_pkg::CMD_ADD, 6'd0, 6'd63);
        send_request(gdfw_pkg::CMD_ADD, 6'd63, 6'd0);
        send_request(gdfw_pkg::CMD_ADD, 6'd5, 6'd5);
        send_request(gdfw_pkg::CMD_ADD, 6'd42, 6'd21);
        send_request(gdfw_pkg::CMD_WALK, 6'd63, 6'd63);
        send_request(gdfw_pkg::CMD_WALK, 6'd0, 6'd0);
        steady = 1'b0;
        send_request(gdfw_pkg::CMD_WALK, 6'd5, 6'd0);
        send_request(CMD_UNUSED, 6'd63, 6'd63);
        send_request(gdfw_pkg::CMD_WALK, 6'd21, 6'd42);
        send_request(gdfw_pkg::CMD_ADD, 6'd1, 6'd2);
        send_request(gdfw_pkg::CMD_ADD, 6'd2, 6'd3);
        send_request(gdfw_pkg::CMD_ADD, 6'd3, 6'd4);
        send_request(gdfw_pkg::CMD_ADD, 6'd1, 6'd4);
        send_request(gdfw_pkg::CMD_ADD, 6'd4, 6'd42);
        send_request(gdfw_pkg::CMD_WALK, 6'd3, 6'd0);
        send_request(gdfw_pkg::CMD_CLEAR, 6'd63, 6'd63);
        send_request(gdfw_pkg::CMD_WALK, 6'd3, 6'd0);
        send_request(CMD_UNUSED, 6'd0, 6'd0);
        drain_reports();

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            // Filling the store takes more requests than the whole budget, so it
            // counts toward it and runs once early on.
            if (!store_filled && counted >= FILL_AFTER) begin
                before_fill = requests_sent;
                fill_store();
                drain_reports();
                counted += requests_sent - before_fill;
                store_filled = 1'b1;
            end
            if (r % 37 == 0)
                steady = ~steady;
            if (r < 45) begin
                // Build a small connected-ish graph in a window, then walk it.
                lo = $urandom_range(0, 52);
                n = $urandom_range(4, 20);
                if (r < 8)
                    send_request(gdfw_pkg::CMD_CLEAR, 6'($urandom_range(0, 63)),
                                 6'($urandom_range(0, 63)));
                repeat (n)
                    send_request(gdfw_pkg::CMD_ADD, 6'($urandom_range(lo, lo + 11)),
                                 6'($urandom_range(lo, lo + 11)));
                send_request(gdfw_pkg::CMD_WALK, 6'($urandom_range(lo, lo + 11)),
                             6'($urandom_range(0, 63)));
                counted += n + 1;
            end else if (r < 65) begin
                send_request(gdfw_pkg::CMD_ADD, 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)));
                counted++;
            end else if (r < 85) begin
                send_request(gdfw_pkg::CMD_WALK, 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)));
                counted++;
            end else if (r < 92) begin
                send_request(gdfw_pkg::CMD_CLEAR, 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)));
                counted++;
            end else if (r < 96) begin
                send_request(CMD_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end else begin
                drain_reports();
            end
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (book.awaited.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (book.awaited.size() != 0) begin
            $display("%0t: %0d predicted reports never came out", $time, book.awaited.size());
            book.errors++;
        end
        $display("Sent %0d requests: %0d edges stored, %0d store-full rejections, %0d walks,",
                 requests_sent, book.edges_added, book.store_full, book.walks);
        $display("%0d clears; %0d reports checked, longest walk reported %0d vertices.",
                 book.clears, book.reports_checked, book.longest_walk);
        if (book.errors == 0) begin
            $display("graph_depth_first_walker_test OK");
        end else begin
            $display("graph_depth_first_walker_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gdfw_pkg.sv
hw/rtl/gdfw_ctrl.sv
hw/rtl/gdfw_dp.sv
hw/rtl/graph_depth_first_walker.sv
tb/sv/graph_depth_first_walker_test.sv
